FILE: sv/hlm_pkg.sv
// Shared types and constants for the heartbeat liveness monitor.
package hlm_pkg;

  localparam int OP_W    = 2;
  localparam int NODE_W  = 5;
  localparam int COUNT_W = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX        = 4'd15;
  localparam logic [COUNT_W-1:0] MISS_LIMIT_RESET = 4'd3;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_HELLO    = 2'd1,
    OP_TICK     = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  localparam logic EVT_ACK  = 1'b0;
  localparam logic EVT_DOWN = 1'b1;

  // result of one pass through the miss unit
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               down;
  } miss_res_t;

endpackage

FILE: sv/hlm_if.sv
// Handshake channel interfaces: requests, events and configuration writes.
interface hlm_req_if import hlm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [NODE_W-1:0] node_id;

  modport source (output valid, output operation, output node_id, input ready);
  modport sink   (input valid, input operation, input node_id, output ready);
endinterface

interface hlm_evt_if import hlm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              event_kind;
  logic [NODE_W-1:0] event_node;
  logic              last_event;

  modport source (output valid, output event_kind, output event_node, output last_event,
                  input ready);
  modport sink   (input valid, input event_kind, input event_node, input last_event,
                  output ready);
endinterface

interface hlm_cfg_if import hlm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] miss_limit;

  modport source (output valid, output miss_limit, input ready);
  modport sink   (input valid, input miss_limit, output ready);
endinterface

FILE: sv/hlm_count_ram.sv
// Miss count store: one write port, one registered read port.
module hlm_count_ram
  import hlm_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [COUNT_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [COUNT_W-1:0] rdata
);

  logic [COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/hlm_miss_unit.sv
// Shared saturating increment and limit compare used for every scanned slot.
module hlm_miss_unit
  import hlm_pkg::*;
(
  input  logic [COUNT_W-1:0] count,
  input  logic               heard,
  input  logic [COUNT_W-1:0] limit,
  output miss_res_t          res
);

  logic [COUNT_W-1:0] bumped;

  always_comb begin
    bumped = count;
    if (!heard && (count < COUNT_MAX)) begin
      bumped = count + COUNT_W'(1);
    end
    res.count = bumped;
    res.down  = (bumped >= limit);
  end

endmodule

FILE: sv/heartbeat_liveness_monitor.sv
// Top level of the heartbeat liveness monitor: slot table, tick scanner, event output.
//
// Keeps a table of NODE_SLOTS node slots. A register makes the slot a member,
// marks it heard, clears its miss count and posts one acknowledge event
// (last_event set); a hello marks the slot heard and clears its count with no
// event. Operation code 3 and register or hello items with node ids at or
// above NODE_SLOTS are dropped. A tick walks the slots in ascending order
// through a single shared miss unit: each slot takes a count store read, then
// an update and write back; the tick is accepted first, ends with a closing
// drain step, and the update can wait on the event sink.
// Members whose count reaches miss_limit are removed and reported as
// node-down events; one event is held back until the next one (or the end
// of the walk) shows whether it is the last, which then carries last_event.
// A tick with no node going down posts nothing. The request channel is
// ready only while the scanner is idle; an event waits in an output
// register, so the next item can be taken before the sink takes it. A
// register that arrives while that output register is still full parks its
// acknowledge and holds ready low until the sink takes the waiting event.
// miss_limit may be written at any time the block is idle; reset value 3.
module heartbeat_liveness_monitor
  import hlm_pkg::*;
#(
  parameter int NODE_SLOTS = 32
) (
  input  logic   clk,
  input  logic   rst,
  hlm_req_if.sink   req,
  hlm_evt_if.source evt,
  hlm_cfg_if.sink   cfg
);

  localparam int IDX_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NODE_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_UPD   = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [NODE_SLOTS-1:0] member;
  logic [NODE_SLOTS-1:0] heard;
  logic [COUNT_W-1:0]    miss_limit;
  logic [IDX_W-1:0]      scan_idx;

  // held-back event
  logic              pend_valid;
  logic              pend_kind;
  logic [NODE_W-1:0] pend_node;

  // output register
  logic              out_valid;
  logic              out_kind;
  logic [NODE_W-1:0] out_node;
  logic              out_last;

  logic               accept;
  logic               id_ok;
  logic [IDX_W-1:0]   id_slot;
  logic               out_free;
  logic               out_load;
  logic               slot_member;
  logic               stall;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic               ram_re;
  logic [COUNT_W-1:0] ram_rdata;
  miss_res_t          miss;

  assign req.ready  = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign accept     = req.valid && req.ready;
  assign id_ok      = (32'(req.node_id) < NODE_SLOTS);
  assign id_slot    = IDX_W'(req.node_id);
  assign out_free   = !out_valid || evt.ready;

  assign evt.valid      = out_valid;
  assign evt.event_kind = out_kind;
  assign evt.event_node = out_node;
  assign evt.last_event = out_last;

  assign slot_member = member[scan_idx];

  hlm_miss_unit u_miss (
    .count (ram_rdata),
    .heard (heard[scan_idx]),
    .limit (miss_limit),
    .res   (miss)
  );

  // a new down event needs the held one pushed out first
  assign stall = (state == S_UPD) && slot_member && miss.down && pend_valid && !out_free;

  // output register takes a new event this cycle
  assign out_load = (accept && (op_t'(req.operation) == OP_REGISTER) && id_ok && out_free) ||
                    ((state == S_UPD) && !stall && slot_member && miss.down && pend_valid) ||
                    ((state == S_DRAIN) && pend_valid && out_free);

  // count store access: idle writes from register/hello, scan read/write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_idx;
    ram_wdata = '0;
    ram_re    = (state == S_READ);
    if (accept && id_ok &&
        ((op_t'(req.operation) == OP_REGISTER) || (op_t'(req.operation) == OP_HELLO))) begin
      ram_we    = 1'b1;
      ram_waddr = id_slot;
      ram_wdata = '0;
    end else if ((state == S_UPD) && slot_member && !stall) begin
      ram_we    = 1'b1;
      ram_wdata = miss.down ? '0 : miss.count;
    end
  end

  hlm_count_ram #(
    .DEPTH (NODE_SLOTS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(req.operation))
            OP_REGISTER: if (id_ok && !out_free) state_next = S_DRAIN;
            OP_TICK:     state_next = S_READ;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_READ:  state_next = S_UPD;
      S_UPD: begin
        if (!stall) state_next = (scan_idx == IDX_LAST) ? S_DRAIN : S_READ;
      end
      S_DRAIN: begin
        if (!pend_valid || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      member     <= '0;
      heard      <= '0;
      miss_limit <= MISS_LIMIT_RESET;
      scan_idx   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid && cfg.ready) begin
        miss_limit <= cfg.miss_limit;
      end

      // output register drains unless reloaded below
      if (evt.ready && !out_load) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op_t'(req.operation))
              OP_REGISTER: begin
                if (id_ok) begin
                  member[id_slot] <= 1'b1;
                  heard[id_slot]  <= 1'b1;
                  if (out_free) begin
                    out_valid <= 1'b1;
                    out_kind  <= EVT_ACK;
                    out_node  <= req.node_id;
                    out_last  <= 1'b1;
                  end else begin
                    pend_valid <= 1'b1;
                    pend_kind  <= EVT_ACK;
                    pend_node  <= req.node_id;
                  end
                end
              end
              OP_HELLO: begin
                if (id_ok) heard[id_slot] <= 1'b1;
              end
              OP_TICK:  scan_idx <= '0;
              default: ;
            endcase
          end
        end
        S_READ: ;
        S_UPD: begin
          if (!stall) begin
            if (slot_member && miss.down) begin
              member[scan_idx] <= 1'b0;
              if (pend_valid) begin
                out_valid <= 1'b1;
                out_kind  <= pend_kind;
                out_node  <= pend_node;
                out_last  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_kind  <= EVT_DOWN;
              pend_node  <= NODE_W'(scan_idx);
            end
            if (scan_idx == IDX_LAST) begin
              heard <= '0;
            end else begin
              scan_idx <= scan_idx + IDX_W'(1);
            end
          end
        end
        S_DRAIN: begin
          if (pend_valid && out_free) begin
            out_valid  <= 1'b1;
            out_kind   <= pend_kind;
            out_node   <= pend_node;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
